// ===== src/circular_queue_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Circular queue unit assertion macros
// Concurrent assertion shorthands, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_QUEUE_UNIT_ASSERT_SVH
`define CIRCULAR_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication
`define CQU_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CQU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/cqu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular queue package
// Shared widths, payload types, request and status codes.
// ----------------------------------------------------------------------------
package cqu_pkg;

   localparam int CQU_DEPTH  = 32;
   localparam int CQU_DATA_W = 32;
   localparam int CQU_FUNC_W = 2;
   localparam int CQU_STAT_W = 3;
   localparam int CQU_SIZE_W = 6;

   typedef logic signed [CQU_DATA_W-1:0] data_type;
   typedef logic [CQU_FUNC_W-1:0]        func_type;
   typedef logic [CQU_STAT_W-1:0]        status_type;
   typedef logic [CQU_SIZE_W-1:0]        size_type;

   localparam size_type CQU_SIZE_RESET = size_type'(32);

   localparam func_type FUNC_INSERT = 2'd0;
   localparam func_type FUNC_REMOVE = 2'd1;
   localparam func_type FUNC_LIST   = 2'd2;

   localparam status_type STATUS_INSERTED  = 3'd0;
   localparam status_type STATUS_OVERFLOW  = 3'd1;
   localparam status_type STATUS_REMOVED   = 3'd2;
   localparam status_type STATUS_UNDERFLOW = 3'd3;
   localparam status_type STATUS_LISTED    = 3'd4;

endpackage

// ===== src/cqu_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular queue request channel
// Valid/ready channel carrying one request transaction.
// ----------------------------------------------------------------------------
interface cqu_req_if import cqu_pkg::*; ();

   logic     valid;
   logic     ready;
   func_type func;
   data_type value_in;

   modport source (output valid, output func, output value_in, input ready);
   modport sink   (input valid, input func, input value_in, output ready);

endinterface

// ===== src/cqu_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular queue response channel
// Valid/ready channel carrying one response transaction.
// ----------------------------------------------------------------------------
interface cqu_rsp_if import cqu_pkg::*; ();

   logic       valid;
   logic       ready;
   status_type status;
   data_type   value_out;
   logic       last;

   modport source (output valid, output status, output value_out, output last, input ready);
   modport sink   (input valid, input status, input value_out, input last, output ready);

endinterface

// ===== src/cqu_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular queue RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cqu_ram import cqu_pkg::*; #(
   parameter int WIDTH = CQU_DATA_W,
   parameter int DEPTH = CQU_DEPTH
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/circular_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular queue unit
// Ring-buffer FIFO of signed 32-bit words with a run-time ring size.
// ----------------------------------------------------------------------------
// Requests arrive on req_ch (func, value_in), responses leave on rsp_ch
// (status, value_out, last). csr_we/csr_wdata set the ring size and empty
// the queue; write it only while the unit is idle.
// One request is handled at a time: req_ch.ready is high only in idle.
// Insert, overflow and underflow: response valid in the cycle after accept.
// Remove: the RAM read is registered in ST_REM_RD, then the response is valid in ST_OUT.
// List: one response per stored element (RAM read, then response
// register), oldest first, last set on the newest element.
// Throughput is bounded by handling one request at a time: a new request
// is taken only after the previous response has been accepted.
// A request with an unused func code is consumed with no response.
// Reset empties the queue and sets the ring size to 32 (capped at DEPTH);
// slot contents are not cleared and no clearing pass is needed.
// When the receiver stalls, the response is held and no new request is taken.
// ----------------------------------------------------------------------------
module circular_queue_unit import cqu_pkg::*; #(
   parameter int DEPTH = CQU_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   cqu_req_if.sink  req_ch,
   cqu_rsp_if.source rsp_ch,
   input  logic     csr_we,
   input  size_type csr_wdata
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LEN_W = $clog2(DEPTH + 1);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_REM_RD   = 3'd1;
   localparam logic [2:0] ST_LIST_RD  = 3'd2;
   localparam logic [2:0] ST_LIST_OUT = 3'd3;
   localparam logic [2:0] ST_OUT      = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic             empty_ff, empty_in;
   size_type         size_ff, size_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [LEN_W-1:0] cnt_ff, cnt_in;
   status_type       status_ff, status_in;
   data_type         value_ff, value_in;
   logic             last_ff, last_in;

   logic [LEN_W-1:0] ring_len;
   logic [IDX_W-1:0] tail_nxt;
   logic [IDX_W-1:0] head_nxt;
   logic [IDX_W-1:0] ptr_nxt;
   logic             req_fire;

   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   logic [CQU_DATA_W-1:0] ram_wdata;
   logic                  ram_re;
   logic [IDX_W-1:0]      ram_raddr;
   logic [CQU_DATA_W-1:0] ram_rdata;

   function automatic logic [IDX_W-1:0] ring_adv(input logic [IDX_W-1:0] idx,
                                                 input logic [LEN_W-1:0] len);
      logic [LEN_W:0] nxt;
      nxt = (LEN_W+1)'(idx) + (LEN_W+1)'(1);
      return (nxt >= (LEN_W+1)'(len)) ? '0 : idx + IDX_W'(1);
   endfunction

   always_comb begin
      if (size_ff == '0) begin
         ring_len = LEN_W'(1);
      end else if (7'(size_ff) > 7'(DEPTH)) begin
         ring_len = LEN_W'(DEPTH);
      end else begin
         ring_len = LEN_W'(size_ff);
      end
   end

   assign tail_nxt = ring_adv(tail_ff, ring_len);
   assign head_nxt = ring_adv(head_ff, ring_len);
   assign ptr_nxt  = ring_adv(ptr_ff, ring_len);

   assign req_ch.ready = (state_ff == ST_IDLE) && !csr_we && !reset;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      empty_in  = empty_ff;
      size_in   = size_ff;
      ptr_in    = ptr_ff;
      cnt_in    = cnt_ff;
      status_in = status_ff;
      value_in  = value_ff;
      last_in   = last_ff;
      ram_we    = 1'b0;
      ram_waddr = tail_nxt;
      ram_wdata = req_ch.value_in;
      ram_re    = 1'b0;
      ram_raddr = head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (csr_we) begin
               size_in  = csr_wdata;
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b1;
            end else if (req_fire) begin
               case (req_ch.func)
                  FUNC_INSERT: begin
                     state_in  = ST_OUT;
                     last_in   = 1'b1;
                     status_in = STATUS_INSERTED;
                     value_in  = req_ch.value_in;
                     if (empty_ff) begin
                        head_in   = '0;
                        tail_in   = '0;
                        empty_in  = 1'b0;
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                     end else if (tail_nxt == head_ff) begin
                        status_in = STATUS_OVERFLOW;
                        value_in  = '0;
                     end else begin
                        tail_in = tail_nxt;
                        ram_we  = 1'b1;
                     end
                  end
                  FUNC_REMOVE: begin
                     last_in = 1'b1;
                     if (empty_ff) begin
                        state_in  = ST_OUT;
                        status_in = STATUS_UNDERFLOW;
                        value_in  = '0;
                     end else begin
                        state_in  = ST_REM_RD;
                        status_in = STATUS_REMOVED;
                        ram_re    = 1'b1;
                        if (head_ff == tail_ff) begin
                           head_in  = '0;
                           tail_in  = '0;
                           empty_in = 1'b1;
                        end else begin
                           head_in = head_nxt;
                        end
                     end
                  end
                  FUNC_LIST: begin
                     if (empty_ff) begin
                        state_in  = ST_OUT;
                        status_in = STATUS_UNDERFLOW;
                        value_in  = '0;
                        last_in   = 1'b1;
                     end else begin
                        state_in  = ST_LIST_RD;
                        status_in = STATUS_LISTED;
                        ptr_in    = head_ff;
                        cnt_in    = '0;
                        ram_re    = 1'b1;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_REM_RD: begin
            value_in = ram_rdata;
            state_in = ST_OUT;
         end
         ST_LIST_RD: begin
            value_in = ram_rdata;
            last_in  = (ptr_ff == tail_ff) ||
                       ((LEN_W+1)'(cnt_ff) + (LEN_W+1)'(1) == (LEN_W+1)'(ring_len));
            state_in = ST_LIST_OUT;
         end
         ST_LIST_OUT: begin
            if (rsp_ch.ready) begin
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in    = ptr_nxt;
                  cnt_in    = cnt_ff + LEN_W'(1);
                  ram_re    = 1'b1;
                  ram_raddr = ptr_nxt;
                  state_in  = ST_LIST_RD;
               end
            end
         end
         ST_OUT: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
         size_ff  <= CQU_SIZE_RESET;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
         size_ff  <= size_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      cnt_ff    <= cnt_in;
      status_ff <= status_in;
      value_ff  <= value_in;
      last_ff   <= last_in;
   end

   cqu_ram #(
      .WIDTH (CQU_DATA_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_ch.valid     = (state_ff == ST_OUT) || (state_ff == ST_LIST_OUT);
   assign rsp_ch.status    = status_ff;
   assign rsp_ch.value_out = value_ff;
   assign rsp_ch.last      = last_ff;

`include "circular_queue_unit_assert.svh"

   `CQU_ASSERT_IMPLY(a_empty_ptrs, empty_ff, (head_ff == '0) && (tail_ff == '0), "empty queue with nonzero pointers")
   `CQU_ASSERT_IMPLY(a_ptr_range, !empty_ff, (LEN_W'(head_ff) < ring_len) && (LEN_W'(tail_ff) < ring_len), "pointer outside ring")
   `CQU_ASSERT_IMPLY(a_no_overlap, req_ch.ready, !rsp_ch.valid, "request taken while response pending")
   `CQU_ASSERT_NEXT(a_last_idle, rsp_ch.valid && rsp_ch.ready && rsp_ch.last, state_ff == ST_IDLE, "not idle after final response")

endmodule
